[design/hcb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcb_pkg
// Shared types and constants of the Huffman code builder.
// ----------------------------------------------------------------------------
package hcb_pkg;

  localparam int MaxSymbols = 64;
  localparam int MaxLength  = 1024;
  localparam int NodeW      = 7;
  localparam int LeafW      = 6;
  localparam int CountW     = 7;
  localparam int WeightW    = 11;
  localparam int SymW       = 8;
  localparam int BitsW      = 63;
  localparam int LenW       = 6;

  localparam logic [NodeW-1:0] Nil = 7'd127;

  typedef logic [NodeW-1:0]   node_t;
  typedef logic [WeightW-1:0] weight_t;
  typedef logic [SymW-1:0]    sym_t;

  typedef enum logic [17:0] {
    StIdle  = 18'h00001,
    StDrain = 18'h00002,
    StSrdI  = 18'h00004,
    StSldI  = 18'h00008,
    StScmp  = 18'h00010,
    StSwrI  = 18'h00020,
    StLinit = 18'h00040,
    StBrl   = 18'h00080,
    StBrr   = 18'h00100,
    StBsum  = 18'h00200,
    StBpr   = 18'h00400,
    StBscan = 18'h00800,
    StBlnk  = 18'h01000,
    StBnl   = 18'h02000,
    StBnl2  = 18'h04000,
    StEstrt = 18'h08000,
    StEwalk = 18'h10000,
    StSpare = 18'h20000
  } state_e;

endpackage

[design/hcb_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcb_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module hcb_ram #(
  parameter int Width = 8,
  parameter int AddrW = 7
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [2**AddrW];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

[design/huffman_code_builder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// huffman_code_builder
// Counts message symbols and builds one Huffman code per distinct symbol.
// ----------------------------------------------------------------------------
// Usage: drive symbol_i and last_i with start_i high; a beat is taken when
// busy_o is low. While a message streams in, one beat is taken every cycle:
// a parallel match over the symbol table picks the counter entry, and the
// weight memory does a read-modify-write with forwarding of the last write.
// The beat with last_i set starts the build and raises busy_o. The build
// sorts the leaves (one comparison per weight memory read), links and
// merges the list, scanning past lighter nodes to place each parent, and
// walks each leaf to the root one code bit at a time, all bounded by the
// single read port of each memory. Each code leaves on the result ports for
// one cycle with result_valid_o high; the receiver must take it then.
// busy_o falls in the same cycle as the last code appears. Reset clears the
// counters and the sequencer; memory contents are not cleared, since only
// entries of the current message are ever read.
// ----------------------------------------------------------------------------
module huffman_code_builder (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic [hcb_pkg::SymW-1:0]     symbol_i,
  input  logic                         last_i,
  output logic                         result_valid_o,
  output logic [hcb_pkg::SymW-1:0]     code_symbol_o,
  output logic [hcb_pkg::WeightW-1:0]  symbol_weight_o,
  output logic [hcb_pkg::BitsW-1:0]    code_bits_o,
  output logic [hcb_pkg::LenW-1:0]     code_length_o,
  output logic                         last_code_o,
  output logic                         overflow_o
);
  import hcb_pkg::*;

  state_e state_q, state_d;

  // Symbol match table, written in order of first appearance.
  sym_t cam_q [MaxSymbols];

  logic [CountW-1:0]  dc_q, dc_d;
  logic [WeightW-1:0] ml_q, ml_d;
  logic               drop_q, drop_d;

  // Counting write stage and forwarding of the last write.
  logic    pv_q, pnew_q, wv_q;
  node_t   pidx_q, widx_q;
  weight_t wval_q, cnt_val;

  // Sequencer registers.
  node_t   i_q, i_d, j_q, j_d, l_q, l_d, r_q, r_d, t_q, t_d;
  node_t   p_q, p_d, q_q, q_d, q0_q, q0_d, root_q, root_d, node_q, node_d;
  weight_t wi_q, wi_d, wl_q, wl_d, wt_q, wt_d;
  sym_t    si_q, si_d;
  logic [BitsW-1:0] bits_q, bits_d, mask_q, mask_d;
  logic [LenW-1:0]  len_q, len_d;

  // Memory ports.
  logic    w_we, w_re, s_we, s_re, p_we, p_re, l_we, l_re;
  node_t   w_wa, w_ra, p_wa, p_ra, l_wa, l_ra, l_wd, l_rd;
  logic [LeafW-1:0] s_wa, s_ra;
  weight_t w_wd, w_rd;
  sym_t    s_wd, s_rd;
  logic [NodeW:0] p_wd, p_rd;

  hcb_ram #(.Width(WeightW), .AddrW(NodeW)) u_wmem (
    .clk_i, .we_i(w_we), .waddr_i(w_wa), .wdata_i(w_wd),
    .re_i(w_re), .raddr_i(w_ra), .rdata_o(w_rd));
  hcb_ram #(.Width(SymW), .AddrW(LeafW)) u_smem (
    .clk_i, .we_i(s_we), .waddr_i(s_wa), .wdata_i(s_wd),
    .re_i(s_re), .raddr_i(s_ra), .rdata_o(s_rd));
  hcb_ram #(.Width(NodeW + 1), .AddrW(NodeW)) u_pmem (
    .clk_i, .we_i(p_we), .waddr_i(p_wa), .wdata_i(p_wd),
    .re_i(p_re), .raddr_i(p_ra), .rdata_o(p_rd));
  hcb_ram #(.Width(NodeW), .AddrW(NodeW)) u_lmem (
    .clk_i, .we_i(l_we), .waddr_i(l_wa), .wdata_i(l_wd),
    .re_i(l_re), .raddr_i(l_ra), .rdata_o(l_rd));

  // Input match.
  logic [MaxSymbols-1:0] hit;
  node_t m_idx;
  logic accept, is_hit, take, drop, new_sym;

  always_comb begin
    m_idx = '0;
    for (int k = 0; k < MaxSymbols; k++) begin
      hit[k] = (cam_q[k] == symbol_i) && (CountW'(k) < dc_q);
      if (hit[k]) begin
        m_idx = m_idx | NodeW'(k);
      end
    end
  end

  assign busy_o  = (state_q != StIdle);
  assign accept  = start_i && !busy_o;
  assign is_hit  = |hit;
  assign take    = accept && (symbol_i != '0) && (ml_q < WeightW'(MaxLength))
                   && (is_hit || (dc_q < CountW'(MaxSymbols)));
  assign drop    = accept && (symbol_i != '0) && !take;
  assign new_sym = take && !is_hit;

  always_comb begin
    if (pnew_q) begin
      cnt_val = WeightW'(1);
    end else if (wv_q && (widx_q == pidx_q)) begin
      cnt_val = wval_q + WeightW'(1);
    end else begin
      cnt_val = w_rd + WeightW'(1);
    end
  end

  logic [CountW-1:0] n_c;
  weight_t wsum;
  assign n_c  = dc_q;
  assign wsum = wl_q + w_rd;

  always_comb begin
    state_d = state_q;
    dc_d = dc_q; ml_d = ml_q; drop_d = drop_q;
    i_d = i_q; j_d = j_q; l_d = l_q; r_d = r_q; t_d = t_q;
    p_d = p_q; q_d = q_q; q0_d = q0_q; root_d = root_q; node_d = node_q;
    wi_d = wi_q; wl_d = wl_q; wt_d = wt_q; si_d = si_q;
    bits_d = bits_q; mask_d = mask_q; len_d = len_q;
    w_we = pv_q; w_wa = pidx_q; w_wd = cnt_val;
    w_re = take && is_hit; w_ra = m_idx;
    s_we = new_sym; s_wa = dc_q[LeafW-1:0]; s_wd = symbol_i;
    s_re = 1'b0; s_ra = i_q[LeafW-1:0];
    p_we = 1'b0; p_wa = l_q; p_wd = {1'b0, t_q};
    p_re = 1'b0; p_ra = i_q;
    l_we = 1'b0; l_wa = i_q; l_wd = Nil;
    l_re = 1'b0; l_ra = r_q;
    case (state_q)
      StIdle: begin
        if (take) begin
          ml_d = ml_q + WeightW'(1);
          if (new_sym) begin
            dc_d = dc_q + CountW'(1);
          end
        end
        if (drop) begin
          drop_d = 1'b1;
        end
        if (accept && last_i) begin
          state_d = StDrain;
        end
      end
      StDrain: begin
        i_d = '0;
        if (n_c == '0) begin
          dc_d = '0; ml_d = '0; drop_d = 1'b0;
          state_d = StIdle;
        end else if (n_c == CountW'(1)) begin
          root_d  = '0;
          state_d = StEstrt;
        end else begin
          state_d = StSrdI;
        end
      end
      StSrdI: begin
        w_re = 1'b1; w_ra = i_q; s_re = 1'b1; s_ra = i_q[LeafW-1:0];
        state_d = StSldI;
      end
      StSldI: begin
        wi_d = w_rd; si_d = s_rd;
        j_d = i_q + NodeW'(1);
        w_re = 1'b1; w_ra = j_d; s_re = 1'b1; s_ra = j_d[LeafW-1:0];
        state_d = StScmp;
      end
      StScmp: begin
        if (wi_q > w_rd) begin
          w_we = 1'b1; w_wa = j_q; w_wd = wi_q;
          s_we = 1'b1; s_wa = j_q[LeafW-1:0]; s_wd = si_q;
          wi_d = w_rd; si_d = s_rd;
        end
        if (CountW'(j_q) + CountW'(1) < n_c) begin
          j_d = j_q + NodeW'(1);
          w_re = 1'b1; w_ra = j_d; s_re = 1'b1; s_ra = j_d[LeafW-1:0];
        end else begin
          state_d = StSwrI;
        end
      end
      StSwrI: begin
        w_we = 1'b1; w_wa = i_q; w_wd = wi_q;
        s_we = 1'b1; s_wa = i_q[LeafW-1:0]; s_wd = si_q;
        if (CountW'(i_q) + CountW'(2) < n_c) begin
          i_d = i_q + NodeW'(1);
          state_d = StSrdI;
        end else begin
          i_d = '0;
          state_d = StLinit;
        end
      end
      StLinit: begin
        // Chain the sorted leaves into the work list.
        l_we = 1'b1; l_wa = i_q;
        l_wd = (CountW'(i_q) + CountW'(1) < n_c) ? i_q + NodeW'(1) : Nil;
        if (CountW'(i_q) + CountW'(1) < n_c) begin
          i_d = i_q + NodeW'(1);
        end else begin
          l_d = '0; r_d = NodeW'(1); t_d = NodeW'(n_c);
          state_d = StBrl;
        end
      end
      StBrl: begin
        w_re = 1'b1; w_ra = l_q;
        state_d = StBrr;
      end
      StBrr: begin
        wl_d = w_rd;
        w_re = 1'b1; w_ra = r_q; l_re = 1'b1; l_ra = r_q;
        state_d = StBsum;
      end
      StBsum: begin
        wt_d = wsum;
        w_we = 1'b1; w_wa = t_q; w_wd = wsum;
        p_we = 1'b1; p_wa = l_q; p_wd = {1'b0, t_q};
        q_d = l_rd; q0_d = l_rd; p_d = r_q;
        w_re = 1'b1; w_ra = l_rd; l_re = 1'b1; l_ra = l_rd;
        state_d = StBpr;
      end
      StBpr: begin
        p_we = 1'b1; p_wa = r_q; p_wd = {1'b1, t_q};
        state_d = StBscan;
      end
      StBscan: begin
        if ((q_q != Nil) && (w_rd < wt_q)) begin
          p_d = q_q; q_d = l_rd;
          w_re = 1'b1; w_ra = l_rd; l_re = 1'b1; l_ra = l_rd;
        end else begin
          l_we = 1'b1; l_wa = p_q; l_wd = t_q;
          state_d = StBlnk;
        end
      end
      StBlnk: begin
        l_we = 1'b1; l_wa = t_q; l_wd = q_q;
        l_d = (p_q == r_q) ? t_q : q0_q;
        state_d = StBnl;
      end
      StBnl: begin
        l_re = 1'b1; l_ra = l_q;
        state_d = StBnl2;
      end
      StBnl2: begin
        if (l_rd == Nil) begin
          root_d = t_q; i_d = '0;
          state_d = StEstrt;
        end else begin
          r_d = l_rd; t_d = t_q + NodeW'(1);
          state_d = StBrl;
        end
      end
      StEstrt: begin
        w_re = 1'b1; w_ra = i_q; s_re = 1'b1; s_ra = i_q[LeafW-1:0];
        p_re = 1'b1; p_ra = i_q;
        node_d = i_q; len_d = '0; bits_d = '0; mask_d = BitsW'(1);
        state_d = StEwalk;
      end
      StEwalk: begin
        if ((node_q == root_q) || (len_q == '1)) begin
          if (CountW'(i_q) + CountW'(1) < n_c) begin
            i_d = i_q + NodeW'(1);
            state_d = StEstrt;
          end else begin
            dc_d = '0; ml_d = '0; drop_d = 1'b0;
            state_d = StIdle;
          end
        end else begin
          if (p_rd[NodeW]) begin
            bits_d = bits_q | mask_q;
          end
          mask_d = {mask_q[BitsW-2:0], 1'b0};
          len_d  = len_q + LenW'(1);
          node_d = p_rd[NodeW-1:0];
          p_re = 1'b1; p_ra = p_rd[NodeW-1:0];
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  logic emit;
  assign emit = (state_q == StEwalk) && ((node_q == root_q) || (len_q == '1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      dc_q <= '0; ml_q <= '0; drop_q <= 1'b0;
      pv_q <= 1'b0; wv_q <= 1'b0;
      result_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      dc_q <= dc_d; ml_q <= ml_d; drop_q <= drop_d;
      pv_q <= take;
      wv_q <= pv_q;
      result_valid_o <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (new_sym) begin
      cam_q[dc_q[LeafW-1:0]] <= symbol_i;
    end
    pnew_q <= new_sym;
    pidx_q <= new_sym ? NodeW'(dc_q) : m_idx;
    widx_q <= pidx_q;
    wval_q <= cnt_val;
    i_q <= i_d; j_q <= j_d; l_q <= l_d; r_q <= r_d; t_q <= t_d;
    p_q <= p_d; q_q <= q_d; q0_q <= q0_d; root_q <= root_d; node_q <= node_d;
    wi_q <= wi_d; wl_q <= wl_d; wt_q <= wt_d; si_q <= si_d;
    bits_q <= bits_d; mask_q <= mask_d; len_q <= len_d;
    if (emit) begin
      code_symbol_o   <= s_rd;
      symbol_weight_o <= w_rd;
      code_bits_o     <= bits_q;
      code_length_o   <= len_q;
      last_code_o     <= (CountW'(i_q) + CountW'(1) == n_c);
      overflow_o      <= drop_q;
    end
  end

  // The counting write must have landed before the sort reads the table.
  a_drain_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StSrdI) |-> !pv_q) else $error("count write pending in sort");

  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dc_q <= CountW'(MaxSymbols)) else $error("distinct count beyond capacity");

  a_emit_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(state_q == StEwalk)) else $error("stray result");

  a_idle_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && last_code_o) |-> (state_q == StIdle))
    else $error("busy after final code");

endmodule

[test/huffman_code_builder_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// huffman_code_builder_tb
// Drives messages into the Huffman code builder and checks every code beat
// against a behavioral code predictor. A short directed table covers the
// corner cases. Generated messages then fill the table and exceed the length
// limit, and random messages follow. Sender idle bursts and drain pauses
// are mixed in along the way.
// ----------------------------------------------------------------------------
module huffman_code_builder_tb;
  import hcb_pkg::*;

  localparam int NodeCount = 2 * MaxSymbols - 1;

  typedef struct {
    logic [SymW-1:0]    sym;
    logic [WeightW-1:0] weight;
    logic [BitsW-1:0]   bits;
    logic [LenW-1:0]    len;
    logic               fin;
    logic               ovf;
  } code_t;

  typedef enum logic [1:0] {KPredict, KOneCode, KNoCode} row_kind_e;

  typedef struct {
    logic [SymW-1:0]    sym;
    logic               last;
    row_kind_e          kind;
    logic [WeightW-1:0] weight;
  } row_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 start_i = 1'b0;
  logic [SymW-1:0]      symbol_i = '0;
  logic                 last_i = 1'b0;
  logic                 busy_o, result_valid_o, last_code_o, overflow_o;
  logic [SymW-1:0]      code_symbol_o;
  logic [WeightW-1:0]   symbol_weight_o;
  logic [BitsW-1:0]     code_bits_o;
  logic [LenW-1:0]      code_length_o;

  code_t pending_codes[$];
  int    errors = 0;
  bit    quiet_phase = 1'b0;

  // Shadow state of the code builder.
  logic [SymW-1:0] leaf_sym[MaxSymbols];
  int              node_wt[NodeCount];
  int              node_up[NodeCount];
  bit              node_right[NodeCount];
  int              next_in_list[NodeCount];
  int              n_distinct = 0;
  int              msg_count = 0;
  bit              dropped = 1'b0;

  always #6 clk_i = ~clk_i;

  huffman_code_builder dut (.*);

  // Counts one symbol and, on last, returns the codes it produces.
  function automatic void predict_codes(input logic [SymW-1:0] sym, input logic last,
                                        output code_t codes[$]);
    int m, root, l, r, t, p, q, nxt, len, nd, w;
    logic [SymW-1:0] s;
    logic [BitsW-1:0] bits;
    codes = {};
    if (sym != 0) begin
      m = n_distinct;
      for (int i = 0; i < n_distinct; i++)
        if (leaf_sym[i] == sym && m == n_distinct) m = i;
      if (msg_count >= MaxLength) dropped = 1'b1;
      else if (m < n_distinct) begin
        node_wt[m]++;
        msg_count++;
      end else if (n_distinct < MaxSymbols) begin
        leaf_sym[n_distinct] = sym;
        node_wt[n_distinct] = 1;
        n_distinct++;
        msg_count++;
      end else dropped = 1'b1;
    end
    if (!last) return;
    if (n_distinct == 1) begin
      codes.push_back('{leaf_sym[0], WeightW'(node_wt[0]), '0, '0, 1'b1, dropped});
    end else if (n_distinct >= 2) begin
      for (int i = 0; i < n_distinct; i++)
        for (int j = i + 1; j < n_distinct; j++)
          if (node_wt[i] > node_wt[j]) begin
            w = node_wt[i]; node_wt[i] = node_wt[j]; node_wt[j] = w;
            s = leaf_sym[i]; leaf_sym[i] = leaf_sym[j]; leaf_sym[j] = s;
          end
      for (int i = 0; i < n_distinct; i++)
        next_in_list[i] = (i + 1 < n_distinct) ? i + 1 : int'(Nil);
      nxt = n_distinct;
      t = 0;
      l = 0;
      r = next_in_list[0];
      for (int g = 0; g < n_distinct - 1 && r < NodeCount && nxt < NodeCount; g++) begin
        t = nxt++;
        node_wt[t] = node_wt[l] + node_wt[r];
        node_up[l] = t;
        node_up[r] = t;
        node_right[l] = 1'b0;
        node_right[r] = 1'b1;
        p = r;
        q = next_in_list[r];
        while (q < NodeCount && node_wt[q] < node_wt[t]) begin
          p = q;
          q = next_in_list[q];
        end
        next_in_list[p] = t;
        next_in_list[t] = q;
        l = next_in_list[r];
        if (l >= NodeCount || next_in_list[l] >= NodeCount) break;
        r = next_in_list[l];
      end
      root = t;
      for (int i = 0; i < n_distinct; i++) begin
        bits = '0;
        len = 0;
        nd = i;
        for (int g = 0; g < NodeCount && nd != root && nd < NodeCount && len < BitsW; g++) begin
          bits[len] = node_right[nd];
          len++;
          nd = node_up[nd];
        end
        codes.push_back('{leaf_sym[i], WeightW'(node_wt[i]), bits, LenW'(len),
                          i + 1 == n_distinct, dropped});
      end
    end
    n_distinct = 0;
    msg_count = 0;
    dropped = 1'b0;
  endfunction

  task automatic report_mismatch(input string what, input logic [BitsW-1:0] got,
                                 input logic [BitsW-1:0] want);
    $display("%0t ns: code %s mismatch: got %0h, expected %0h", $time, what, got, want);
    errors++;
  endtask

  // One symbol beat; typed rows replace the predicted codes with literal ones.
  task automatic send_symbol(input logic [SymW-1:0] sym, input logic last,
                             input row_kind_e kind = KPredict,
                             input logic [WeightW-1:0] weight = '0);
    code_t codes[$];
    if (!quiet_phase && $urandom_range(3) == 0) begin
      @(negedge clk_i);
      start_i = 1'b0;
      repeat ($urandom_range(5, 1) - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    start_i = 1'b1;
    symbol_i = sym;
    last_i = last;
    do @(posedge clk_i); while (busy_o);
    predict_codes(sym, last, codes);
    if (kind == KOneCode) pending_codes.push_back('{sym, weight, '0, '0, 1'b1, 1'b0});
    else if (kind == KPredict) foreach (codes[k]) pending_codes.push_back(codes[k]);
  endtask

  task automatic drain_codes();
    @(negedge clk_i);
    start_i = 1'b0;
    while (pending_codes.size() != 0) @(negedge clk_i);
  endtask

  always @(posedge clk_i) begin
    code_t want;
    if (rst_ni && result_valid_o) begin
      if (pending_codes.size() == 0) begin
        report_mismatch("unexpected beat", BitsW'(code_symbol_o), '0);
      end else begin
        want = pending_codes.pop_front();
        if (code_symbol_o !== want.sym)
          report_mismatch("symbol", BitsW'(code_symbol_o), BitsW'(want.sym));
        if (symbol_weight_o !== want.weight)
          report_mismatch("weight", BitsW'(symbol_weight_o), BitsW'(want.weight));
        if (code_bits_o !== want.bits) report_mismatch("bits", code_bits_o, want.bits);
        if (code_length_o !== want.len)
          report_mismatch("length", BitsW'(code_length_o), BitsW'(want.len));
        if (last_code_o !== want.fin)
          report_mismatch("last", BitsW'(last_code_o), BitsW'(want.fin));
        if (overflow_o !== want.ovf)
          report_mismatch("overflow", BitsW'(overflow_o), BitsW'(want.ovf));
      end
    end
  end

  initial begin
    #5ms;
    $display("huffman_code_builder_tb: done, errors");
    $finish;
  end

  initial begin
    row_t directed[];
    logic [SymW-1:0] alphabet[8];
    int pool, msg_len;
    directed = '{
      '{8'h41, 1'b1, KOneCode, 11'd1},  // lone symbol right after reset
      '{8'h00, 1'b1, KNoCode,  11'd0},  // empty message
      '{8'hFF, 1'b0, KPredict, 11'd0},
      '{8'h01, 1'b0, KPredict, 11'd0},
      '{8'hFF, 1'b0, KPredict, 11'd0},
      '{8'h80, 1'b1, KPredict, 11'd0},
      '{8'h55, 1'b0, KPredict, 11'd0},
      '{8'h00, 1'b0, KPredict, 11'd0},  // zero symbol is ignored
      '{8'h55, 1'b1, KOneCode, 11'd2},
      '{8'hAA, 1'b0, KPredict, 11'd0},
      '{8'h55, 1'b0, KPredict, 11'd0},
      '{8'h0F, 1'b0, KPredict, 11'd0},
      '{8'hF0, 1'b0, KPredict, 11'd0},
      '{8'h33, 1'b0, KPredict, 11'd0},
      '{8'hCC, 1'b1, KPredict, 11'd0}
    };
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed[k])
      send_symbol(directed[k].sym, directed[k].last, directed[k].kind, directed[k].weight);
    drain_codes();

    // Table full: 66 distinct symbols, then known ones, then a dropped last.
    for (int k = 1; k <= 66; k++) send_symbol(k[7:0], 1'b0);
    send_symbol(8'd3, 1'b0);
    send_symbol(8'd3, 1'b0);
    send_symbol(8'd200, 1'b1);
    drain_codes();

    // Message too long: the last beat lands past the length limit.
    for (int k = 0; k < MaxLength + 3; k++)
      send_symbol((k % 3 == 0) ? 8'h9C : ((k % 5 == 0) ? 8'h63 : 8'h7E), 1'b0);
    send_symbol(8'h9C, 1'b1);

    for (int items = 0; items < 110; ) begin
      if (items > 85) quiet_phase = 1'b1;
      pool = $urandom_range(8, 1);
      foreach (alphabet[k]) alphabet[k] = SymW'($urandom_range(255, 1));
      msg_len = $urandom_range(12, 1);
      for (int k = 0; k < msg_len; k++) begin
        if ($urandom_range(15) == 0) send_symbol(SymW'($urandom_range(255)), k == msg_len - 1);
        else send_symbol(alphabet[$urandom_range(pool - 1)], k == msg_len - 1);
        items++;
      end
      if (items > 40 && items < 55) drain_codes();
    end

    drain_codes();
    repeat (200) @(posedge clk_i);
    if (errors == 0) $display("huffman_code_builder_tb: done, clean");
    else $display("huffman_code_builder_tb: done, errors");
    $finish;
  end

endmodule

[huffman_code_builder.f]
design/hcb_pkg.sv
design/hcb_ram.sv
design/huffman_code_builder.sv
test/huffman_code_builder_tb.sv
